### src/radial_pattern_index_map_assert.svh
// ----------------------------------------------------------------------------
// radial_pattern_index_map_assert.svh
// Assertion macros used by the radial pattern index map RTL.
// ----------------------------------------------------------------------------
`ifndef RADIAL_PATTERN_INDEX_MAP_ASSERT_SVH
`define RADIAL_PATTERN_INDEX_MAP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define RPIM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RPIM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rpim_pkg.sv
// ----------------------------------------------------------------------------
// rpim_pkg
// Widths, register codes and iteration helpers for the radial pattern map.
// ----------------------------------------------------------------------------
package rpim_pkg;

	localparam int COORD_BITS = 8;
	localparam int PORT_BITS  = 8;
	// coordinates used after masking to the smaller of COORD_BITS and PORT_BITS
	localparam int CW = (COORD_BITS < PORT_BITS) ? COORD_BITS : PORT_BITS;
	localparam int RES_BITS = 8;

	localparam int N_ITER_STG = 4;

	// divider: dividend |dy|*res, divisor |dx|
	localparam int QW    = CW + RES_BITS;
	localparam int DSTEP = (QW + N_ITER_STG - 1) / N_ITER_STG;
	localparam int QP    = DSTEP * N_ITER_STG;

	// square root: radicand up to 2*CW+1 bits, root up to CW+1 bits
	localparam int SQ_BITS = 2 * CW + 1;
	localparam int RB      = CW + 1;
	localparam int SSTEP   = (RB + N_ITER_STG - 1) / N_ITER_STG;
	localparam int RBP     = SSTEP * N_ITER_STG;

	localparam int WRAP_BITS = 16;
	localparam int QS_BITS   = (QP + 1 > WRAP_BITS) ? QP + 1 : WRAP_BITS;

	localparam logic [8:0] MOD_BASE = 9'd255;

	typedef enum logic [1:0] {
		REG_SPOKE_MODE = 2'd0,
		REG_CENTER_X   = 2'd1,
		REG_CENTER_Y   = 2'd2,
		REG_SPOKE_RES  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CW-1:0] rem;
		logic [QP-1:0] quo;
	} div_st_t;

	typedef struct packed {
		logic [RBP+1:0]   rem;
		logic [RBP-1:0]   root;
		logic [2*RBP-1:0] rad;
	} sqr_st_t;

	// DSTEP restoring division steps, dividend shifted out of quo MSB first
	function automatic div_st_t div_iter(div_st_t st, logic [CW-1:0] dv);
		div_st_t r;
		logic [CW:0] t;
		r = st;
		for (int i = 0; i < DSTEP; i++) begin
			t = {r.rem, r.quo[QP-1]};
			if (t >= {1'b0, dv}) begin
				t = t - {1'b0, dv};
				r.quo = {r.quo[QP-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[QP-2:0], 1'b0};
			end
			r.rem = t[CW-1:0];
		end
		return r;
	endfunction

	// SSTEP digit-by-digit square root steps, two radicand bits each
	function automatic sqr_st_t sqr_iter(sqr_st_t st);
		sqr_st_t r;
		logic [RBP+3:0] t;
		logic [RBP+3:0] trial;
		r = st;
		for (int i = 0; i < SSTEP; i++) begin
			t     = {r.rem, r.rad[2*RBP-1 -: 2]};
			trial = (RBP+4)'({r.root, 2'b01});
			if (t >= trial) begin
				t = t - trial;
				r.root = {r.root[RBP-2:0], 1'b1};
			end else begin
				r.root = {r.root[RBP-2:0], 1'b0};
			end
			r.rem = t[RBP+1:0];
			r.rad = {r.rad[2*RBP-3:0], 2'b00};
		end
		return r;
	endfunction

endpackage

### src/radial_pattern_index_map.sv
// ----------------------------------------------------------------------------
// radial_pattern_index_map
// Pixel coordinate to palette index for ring or spoke patterns.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while in_stall is low and returns its palette index.
// The pipeline is nine register stages: offset from centre, multiplies, square
// sum, four stages of the shared-shape division / square-root iteration (each
// does DSTEP division and SSTEP root steps), sign wrap, and the mod-255 fold
// into the output register. A stall on the result side holds every stage, so
// the input stalls only while a finished result waits to be taken. The
// configuration port is always ready; write it only while the pipeline is empty.
`include "radial_pattern_index_map_assert.svh"

module radial_pattern_index_map
	import rpim_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PORT_BITS-1:0] pixel_x,
	input  logic [PORT_BITS-1:0] pixel_y,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           color_index,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);

	logic                spoke_mode_q;
	logic [7:0]          center_x_q;
	logic [7:0]          center_y_q;
	logic [RES_BITS-1:0] spoke_res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spoke_mode_q <= 1'b0;
			center_x_q   <= 8'd0;
			center_y_q   <= 8'd0;
			spoke_res_q  <= RES_BITS'(10);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SPOKE_MODE: spoke_mode_q <= cfg_data[0];
				REG_CENTER_X:   center_x_q   <= cfg_data;
				REG_CENTER_Y:   center_y_q   <= cfg_data;
				REG_SPOKE_RES:  spoke_res_q  <= cfg_data[RES_BITS-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances together unless the output transfer is held
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0; valid_s2 <= 1'b0; valid_s3 <= 1'b0;
			valid_s4 <= 1'b0; valid_s5 <= 1'b0; valid_s6 <= 1'b0;
			valid_s7 <= 1'b0; valid_s8 <= 1'b0; valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1; valid_s3 <= valid_s2; valid_s4 <= valid_s3;
			valid_s5 <= valid_s4; valid_s6 <= valid_s5; valid_s7 <= valid_s6;
			valid_s8 <= valid_s7; valid_s9 <= valid_s8;
		end
	end

	// ---- stage 1: offsets and magnitudes
	logic [CW:0]   dx_c, dy_c;
	logic [CW-1:0] ax_s1, ay_s1;
	logic          neg_s1, axis_s1, spoke_s1;
	logic [RES_BITS-1:0] res_s1;

	assign dx_c = {1'b0, pixel_x[CW-1:0]} - {1'b0, center_x_q[CW-1:0]};
	assign dy_c = {1'b0, pixel_y[CW-1:0]} - {1'b0, center_y_q[CW-1:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1    <= dx_c[CW] ? CW'(-dx_c) : dx_c[CW-1:0];
			ay_s1    <= dy_c[CW] ? CW'(-dy_c) : dy_c[CW-1:0];
			neg_s1   <= dx_c[CW] ^ dy_c[CW];
			axis_s1  <= (dx_c == '0) || (dy_c == '0);
			spoke_s1 <= spoke_mode_q;
			res_s1   <= spoke_res_q;
		end
	end

	// ---- stage 2: products
	logic [QW-1:0]   prod_s2;
	logic [2*CW-1:0] sqx_s2, sqy_s2;
	logic [CW-1:0]   ax_s2;
	logic            neg_s2, axis_s2, spoke_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2  <= QW'(ay_s1 * res_s1);
			sqx_s2   <= (2*CW)'(ax_s1 * ax_s1);
			sqy_s2   <= (2*CW)'(ay_s1 * ay_s1);
			ax_s2    <= ax_s1;
			neg_s2   <= neg_s1;
			axis_s2  <= axis_s1;
			spoke_s2 <= spoke_s1;
		end
	end

	// ---- stage 3: square sum, iteration set-up
	div_st_t       div_s3;
	sqr_st_t       sqr_s3;
	logic [CW-1:0] ax_s3;
	logic          neg_s3, axis_s3, spoke_s3;
	logic [SQ_BITS-1:0] sum_c;

	assign sum_c = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			div_s3.rem  <= '0;
			div_s3.quo  <= QP'(prod_s2);
			sqr_s3.rem  <= '0;
			sqr_s3.root <= '0;
			sqr_s3.rad  <= (2*RBP)'(sum_c);
			ax_s3       <= ax_s2;
			neg_s3      <= neg_s2;
			axis_s3     <= axis_s2;
			spoke_s3    <= spoke_s2;
		end
	end

	// ---- stages 4 to 7: division and square root iterations
	div_st_t       div_s4, div_s5, div_s6, div_s7;
	sqr_st_t       sqr_s4, sqr_s5, sqr_s6, sqr_s7;
	logic [CW-1:0] ax_s4, ax_s5, ax_s6;
	logic          neg_s4, neg_s5, neg_s6, neg_s7;
	logic          axis_s4, axis_s5, axis_s6, axis_s7;
	logic          spoke_s4, spoke_s5, spoke_s6, spoke_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			div_s4 <= div_iter(div_s3, ax_s3);
			sqr_s4 <= sqr_iter(sqr_s3);
			ax_s4  <= ax_s3;  neg_s4 <= neg_s3;  axis_s4 <= axis_s3;  spoke_s4 <= spoke_s3;

			div_s5 <= div_iter(div_s4, ax_s4);
			sqr_s5 <= sqr_iter(sqr_s4);
			ax_s5  <= ax_s4;  neg_s5 <= neg_s4;  axis_s5 <= axis_s4;  spoke_s5 <= spoke_s4;

			div_s6 <= div_iter(div_s5, ax_s5);
			sqr_s6 <= sqr_iter(sqr_s5);
			ax_s6  <= ax_s5;  neg_s6 <= neg_s5;  axis_s6 <= axis_s5;  spoke_s6 <= spoke_s5;

			div_s7 <= div_iter(div_s6, ax_s6);
			sqr_s7 <= sqr_iter(sqr_s6);
			neg_s7 <= neg_s6;  axis_s7 <= axis_s6;  spoke_s7 <= spoke_s6;
		end
	end

	// ---- stage 8: sign, 16-bit wrap, mode select
	logic [QS_BITS-1:0]   qs_c;
	logic [WRAP_BITS-1:0] wrap_s8;

	assign qs_c = neg_s7 ? QS_BITS'(-QS_BITS'(div_s7.quo)) : QS_BITS'(div_s7.quo);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!spoke_s7)
				wrap_s8 <= WRAP_BITS'(sqr_s7.root);
			else if (axis_s7)
				wrap_s8 <= '0;
			else
				wrap_s8 <= qs_c[WRAP_BITS-1:0];
		end
	end

	// ---- stage 9: mod 255 via 256 == 1 fold, into the output register
	logic [8:0] fold_c, fold_sub_c;
	logic [7:0] color_index_s9;

	assign fold_c     = {1'b0, wrap_s8[15:8]} + {1'b0, wrap_s8[7:0]};
	assign fold_sub_c = (fold_c >= MOD_BASE) ? fold_c - MOD_BASE : fold_c;

	always_ff @(posedge clk) begin
		if (en)
			color_index_s9 <= (fold_sub_c == MOD_BASE) ? 8'd0 : fold_sub_c[7:0];
	end

	assign out_valid   = valid_s9;
	assign color_index = color_index_s9;

	`RPIM_ASSERT_NOW(a_index_range, out_valid, color_index != 8'd255, "index reached 255")
	`RPIM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without held result")
	`RPIM_ASSERT_NEXT(a_stage_hold, valid_s5 && in_stall, valid_s5, "held stage lost its item")
	`RPIM_ASSERT_NOW(a_out_source, $rose(out_valid), $past(valid_s8), "result without a source item")

endmodule
